### rtl/lgen_pkg.sv
`timescale 1ns / 1ps
package lgen_pkg;

	localparam int FUNC_W    = 2;
	localparam int IDX_W     = 6;
	localparam int CELLS_W   = 64;
	localparam int REG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam logic [REG_W-1:0] ROWS_RESET = 7'd20;
	localparam logic [REG_W-1:0] COLS_RESET = 7'd40;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_READ = 2'd1,
		FUNC_STEP = 2'd2,
		FUNC_RSVD = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GEN,
		ST_WAIT,
		ST_TAIL,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

### rtl/lgen_req_if.sv
`timescale 1ns / 1ps
interface lgen_req_if;
	logic                            valid;
	logic                            ready;
	logic [lgen_pkg::FUNC_W-1:0]     func;
	logic [lgen_pkg::IDX_W-1:0]      row_index;
	logic [lgen_pkg::CELLS_W-1:0]    row_cells;

	modport source (output valid, output func, output row_index, output row_cells, input ready);
	modport sink (input valid, input func, input row_index, input row_cells, output ready);
endinterface

### rtl/lgen_rsp_if.sv
`timescale 1ns / 1ps
interface lgen_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [lgen_pkg::CELLS_W-1:0]    cells_out;
	logic [lgen_pkg::FUNC_W-1:0]     echo_func;
	logic                            index_error;

	modport source (output valid, output cells_out, output echo_func, output index_error,
		input ready);
	modport sink (input valid, input cells_out, input echo_func, input index_error,
		output ready);
endinterface

### rtl/lgen_cfg_if.sv
`timescale 1ns / 1ps
interface lgen_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lgen_pkg::CFG_IDX_W-1:0]   index;
	logic [lgen_pkg::REG_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/life_generation_engine_core.sv
`timescale 1ns / 1ps
// Toroidal Game of Life grid, one row word per memory entry, rows and columns in use set by
// registers 0 and 1. A load, a read (shorter when the row index is out of range) and a
// generation step each finish before the next acceptance; a step sweeps the rows in use,
// clamped to 1..MAX_ROWS: the row memory has one read port, so rows stream through the cell lanes
// one per cycle, with all columns of a row worked at once. Every result waits in an output
// register, so an item is taken while the previous beat is unread; a finished item holds in
// its last state, stalling the input, for as long as the output register stays full.
// Reset needs no clearing pass; per-row valid bits make unwritten rows read as zero.
module life_generation_engine_core #(
	parameter int MAX_ROWS = lgen_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lgen_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lgen_req_if.sink    req,
	lgen_rsp_if.source  rsp,
	lgen_cfg_if.sink    cfg
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW = ($clog2(MAX_ROWS + 1) > lgen_pkg::REG_W) ?
		$clog2(MAX_ROWS + 1) : lgen_pkg::REG_W;

	lgen_pkg::state_t state_q, state_nxt;

	logic [lgen_pkg::REG_W-1:0]   rows_q;
	logic [lgen_pkg::REG_W-1:0]   cols_q;
	logic [RW-1:0]                eff_rows;
	logic [lgen_pkg::REG_W-1:0]   eff_cols;
	logic [MAX_COLS-1:0]          col_mask;
	logic [AW-1:0]                last_addr;

	logic                         accept;
	logic                         idx_err;
	logic                         req_ready;
	logic                         gen_issue;
	logic                         tail_en;
	logic                         rsp_load;

	logic [RW-1:0]                step_q;
	logic [RW-1:0]                step_s1;
	logic                         gen_rd_s1;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [MAX_COLS-1:0]          mem_wdata;
	logic [AW-1:0]                mem_raddr;
	logic [MAX_COLS-1:0]          rd_word;

	logic [MAX_COLS-1:0]          prev_q;
	logic [MAX_COLS-1:0]          cur_q;
	logic [MAX_COLS-1:0]          first_q;
	logic                         ru_en;
	logic [AW-1:0]                ru_addr;
	logic [MAX_COLS-1:0]          ru_below;
	logic                         gen_we;
	logic [AW-1:0]                gen_waddr;
	logic [MAX_COLS-1:0]          gen_wdata;

	logic [lgen_pkg::CELLS_W-1:0] res_cells_q;
	logic [lgen_pkg::FUNC_W-1:0]  res_func_q;
	logic                         res_err_q;

	logic                         rsp_valid_q;
	logic [lgen_pkg::CELLS_W-1:0] rsp_cells_q;
	logic [lgen_pkg::FUNC_W-1:0]  rsp_func_q;
	logic                         rsp_err_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lgen_pkg::ROWS_RESET;
			cols_q <= lgen_pkg::COLS_RESET;
		end else if (cfg.valid) begin
			case (lgen_pkg::cfg_reg_t'(cfg.index))
				lgen_pkg::REG_ROWS: rows_q <= cfg.data;
				lgen_pkg::REG_COLS: cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamp the registers into the grid's range
	always_comb begin
		if (rows_q == '0) begin
			eff_rows = RW'(1);
		end else if (RW'(rows_q) > RW'(MAX_ROWS)) begin
			eff_rows = RW'(MAX_ROWS);
		end else begin
			eff_rows = RW'(rows_q);
		end
		if (cols_q == '0) begin
			eff_cols = 7'd1;
		end else if (cols_q > 7'(MAX_COLS)) begin
			eff_cols = 7'(MAX_COLS);
		end else begin
			eff_cols = cols_q;
		end
	end

	for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
		assign col_mask[j] = 7'(j) < eff_cols;
	end

	assign last_addr = AW'(eff_rows - RW'(1));
	assign accept    = req.valid && req_ready;
	assign idx_err   = RW'(req.row_index) >= eff_rows;
	assign req.ready = req_ready;

	// sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lgen_pkg::ST_IDLE: begin
				if (accept) begin
					case (lgen_pkg::func_t'(req.func))
						lgen_pkg::FUNC_READ: state_nxt = idx_err ? lgen_pkg::ST_RESP :
							lgen_pkg::ST_READ;
						lgen_pkg::FUNC_STEP: state_nxt = lgen_pkg::ST_GEN;
						default: state_nxt = lgen_pkg::ST_RESP;
					endcase
				end
			end
			lgen_pkg::ST_READ: state_nxt = lgen_pkg::ST_RESP;
			lgen_pkg::ST_GEN: begin
				if (step_q == eff_rows) begin
					state_nxt = lgen_pkg::ST_WAIT;
				end
			end
			lgen_pkg::ST_WAIT: state_nxt = lgen_pkg::ST_TAIL;
			lgen_pkg::ST_TAIL: state_nxt = lgen_pkg::ST_DRAIN;
			lgen_pkg::ST_DRAIN: state_nxt = lgen_pkg::ST_RESP;
			lgen_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_nxt = lgen_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lgen_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		gen_issue = 1'b0;
		tail_en   = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			lgen_pkg::ST_IDLE: req_ready = 1'b1;
			lgen_pkg::ST_GEN:  gen_issue = 1'b1;
			lgen_pkg::ST_TAIL: tail_en   = 1'b1;
			lgen_pkg::ST_RESP: rsp_load  = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lgen_pkg::ST_IDLE;
			step_q    <= '0;
			gen_rd_s1 <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			step_q    <= gen_issue ? step_q + RW'(1) : '0;
			gen_rd_s1 <= gen_issue;
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= step_q;
	end

	// row memory: loads write at acceptance, the generation writes from the lane stage
	always_comb begin
		mem_we    = gen_we;
		mem_waddr = gen_waddr;
		mem_wdata = gen_wdata;
		if (accept && (req.func == lgen_pkg::FUNC_LOAD) && !idx_err) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(req.row_index);
			mem_wdata = req.row_cells[MAX_COLS-1:0] & col_mask;
		end
		if (gen_issue) begin
			mem_raddr = (step_q == '0) ? last_addr : AW'(step_q - RW'(1));
		end else begin
			mem_raddr = AW'(req.row_index);
		end
	end

	lgen_grid_mem #(
		.DEPTH (MAX_ROWS),
		.WIDTH (MAX_COLS),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (rd_word)
	);

	// first beat is the old bottom row, second the old top row; later beats slide the window
	always_ff @(posedge clk) begin
		if (gen_rd_s1) begin
			if (step_s1 == '0) begin
				prev_q <= rd_word;
			end else if (step_s1 == RW'(1)) begin
				cur_q   <= rd_word;
				first_q <= rd_word;
			end else begin
				prev_q <= cur_q;
				cur_q  <= rd_word;
			end
		end
	end

	assign ru_en    = (gen_rd_s1 && (step_s1 > RW'(1))) || tail_en;
	assign ru_addr  = tail_en ? last_addr : AW'(step_s1 - RW'(2));
	assign ru_below = tail_en ? first_q : rd_word;

	lgen_row_unit #(
		.NCOLS (MAX_COLS),
		.AW    (AW)
	) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (ru_en),
		.addr    (ru_addr),
		.cols    (eff_cols),
		.above   (prev_q),
		.mid     (cur_q),
		.below   (ru_below),
		.wr_en   (gen_we),
		.wr_addr (gen_waddr),
		.wr_data (gen_wdata)
	);

	// pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			res_cells_q <= '0;
			res_func_q  <= req.func;
			res_err_q   <= idx_err && ((req.func == lgen_pkg::FUNC_LOAD) ||
				(req.func == lgen_pkg::FUNC_READ));
		end else if (state_q == lgen_pkg::ST_READ) begin
			res_cells_q <= lgen_pkg::CELLS_W'(rd_word & col_mask);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_cells_q <= res_cells_q;
			rsp_func_q  <= res_func_q;
			rsp_err_q   <= res_err_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.cells_out   = rsp_cells_q;
	assign rsp.echo_func   = rsp_func_q;
	assign rsp.index_error = rsp_err_q;

`ifndef ASSERT_OFF
	a_gen_write_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		gen_we |-> (state_q == lgen_pkg::ST_GEN || state_q == lgen_pkg::ST_WAIT ||
			state_q == lgen_pkg::ST_TAIL || state_q == lgen_pkg::ST_DRAIN))
		else $error("generation write outside a generation step");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != lgen_pkg::ST_IDLE)
		else $error("accepted beat did not start work");

	a_cells_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.echo_func != lgen_pkg::FUNC_READ || rsp.index_error))
			|-> rsp.cells_out == '0)
		else $error("row data on a beat that is not a good read");

	a_error_only_on_row_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.index_error) |->
			(rsp.echo_func == lgen_pkg::FUNC_LOAD || rsp.echo_func == lgen_pkg::FUNC_READ))
		else $error("index error flagged on an operation without a row");
`endif

endmodule

### rtl/lgen_lane.sv
`timescale 1ns / 1ps
module lgen_lane #(
	parameter int NCOLS = lgen_pkg::MAX_COLS_DEF,
	parameter int J     = 0
) (
	input  logic [NCOLS-1:0]              above,
	input  logic [NCOLS-1:0]              mid,
	input  logic [NCOLS-1:0]              below,
	input  logic [lgen_pkg::REG_W-1:0]    cols,
	output logic                          next
);

	localparam int CW = (NCOLS > 1) ? $clog2(NCOLS) : 1;

	logic [lgen_pkg::REG_W-1:0] cols_m1;
	logic [CW-1:0]              left_idx;
	logic [CW-1:0]              right_idx;
	logic [3:0]                 total;

	// wrap at the columns in use; on narrow grids the same cell may be counted more than once
	always_comb begin
		cols_m1   = cols - 7'd1;
		left_idx  = (J == 0) ? cols_m1[CW-1:0] : CW'(J - 1);
		right_idx = (7'(J + 1) == cols) ? '0 : CW'(J + 1);
		total = 4'(above[left_idx]) + 4'(above[J]) + 4'(above[right_idx])
		      + 4'(mid[left_idx]) + 4'(mid[right_idx])
		      + 4'(below[left_idx]) + 4'(below[J]) + 4'(below[right_idx]);
		next = (total == 4'd3) || (mid[J] && (total == 4'd2));
	end

endmodule

### rtl/lgen_row_unit.sv
`timescale 1ns / 1ps
module lgen_row_unit #(
	parameter int NCOLS = lgen_pkg::MAX_COLS_DEF,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [AW-1:0]                 addr,
	input  logic [lgen_pkg::REG_W-1:0]    cols,
	input  logic [NCOLS-1:0]              above,
	input  logic [NCOLS-1:0]              mid,
	input  logic [NCOLS-1:0]              below,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [NCOLS-1:0]              wr_data
);

	logic [NCOLS-1:0] next_w;
	logic [NCOLS-1:0] mask;
	logic [NCOLS-1:0] merged;
	logic             wr_en_s2;
	logic [AW-1:0]    wr_addr_s2;
	logic [NCOLS-1:0] wr_data_s2;

	for (genvar j = 0; j < NCOLS; j++) begin : g_lane
		lgen_lane #(
			.NCOLS (NCOLS),
			.J     (j)
		) u_lane (
			.above (above),
			.mid   (mid),
			.below (below),
			.cols  (cols),
			.next  (next_w[j])
		);
		assign mask[j] = 7'(j) < cols;
	end

	// columns outside the grid keep their old bits
	assign merged = (mid & ~mask) | (next_w & mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s2 <= 1'b0;
		end else begin
			wr_en_s2 <= en;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s2 <= addr;
		wr_data_s2 <= merged;
	end

	assign wr_en   = wr_en_s2;
	assign wr_addr = wr_addr_s2;
	assign wr_data = wr_data_s2;

endmodule

### rtl/lgen_grid_mem.sv
`timescale 1ns / 1ps
module lgen_grid_mem #(
	parameter int DEPTH = lgen_pkg::MAX_ROWS_DEF,
	parameter int WIDTH = lgen_pkg::MAX_COLS_DEF,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_s1;
	logic             rd_valid_s1;

	// a row never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_s1  <= mem[raddr];
		rd_valid_s1 <= valid_q[raddr];
	end

	assign rdata = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import lgen_pkg::*;

	typedef struct {
		func_t       func;
		logic [5:0]  idx;
		logic [63:0] cells;
	} grid_op_t;

	typedef struct {
		logic [63:0] cells;
		func_t       func;
		logic        err;
	} answer_t;

	bit   clk;
	logic arst_n;

	lgen_req_if req_bus();
	lgen_rsp_if rsp_bus();
	lgen_cfg_if cfg_bus();

	life_generation_engine_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	grid_op_t    op_queue[$];
	answer_t     pending_answers[$];
	logic [63:0] life_rows [64] = '{default: '0};
	logic [6:0]  rows_setting = ROWS_RESET;
	logic [6:0]  cols_setting = COLS_RESET;
	int          mismatches = 0;
	int          req_gap = 0;
	int          rsp_hold = 0;
	bit          req_took = 1'b0;
	bit          calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int live_rows();
		if (rows_setting == 7'd0) return 1;
		if (rows_setting > 7'd64) return 64;
		return rows_setting;
	endfunction

	function automatic int live_cols();
		if (cols_setting == 7'd0) return 1;
		if (cols_setting > 7'd64) return 64;
		return cols_setting;
	endfunction

	function automatic logic [63:0] used_cols_mask();
		int n;
		n = live_cols();
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	// Work from a snapshot of the old grid; each of the eight offsets counts on its own,
	// so tiny grids see the same cell more than once.
	function automatic void next_generation();
		logic [63:0] prior [64];
		logic [63:0] fresh;
		int nr, nc, total, rr, cc;
		nr = live_rows();
		nc = live_cols();
		prior = life_rows;
		for (int i = 0; i < nr; i++) begin
			fresh = '0;
			for (int j = 0; j < nc; j++) begin
				total = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0) begin
							rr = (i + nr + dr) % nr;
							cc = (j + nc + dc) % nc;
							total += prior[rr][cc];
						end
					end
				end
				if (prior[i][j] ? (total == 2 || total == 3) : (total == 3))
					fresh[j] = 1'b1;
			end
			life_rows[i] = (prior[i] & ~used_cols_mask()) | fresh;
		end
	endfunction

	function automatic answer_t life_answer(grid_op_t op);
		answer_t ans;
		ans.cells = '0;
		ans.func  = op.func;
		ans.err   = 1'b0;
		case (op.func)
		FUNC_LOAD, FUNC_READ: begin
			if (op.idx >= live_rows())
				ans.err = 1'b1;
			else if (op.func == FUNC_LOAD)
				life_rows[op.idx] = op.cells & used_cols_mask();
			else
				ans.cells = life_rows[op.idx] & used_cols_mask();
		end
		FUNC_STEP: next_generation();
		default: ;
		endcase
		return ans;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic push_op(func_t f, logic [5:0] idx, logic [63:0] cells);
		grid_op_t op;
		op.func  = f;
		op.idx   = idx;
		op.cells = cells;
		op_queue.push_back(op);
	endtask

	// Mostly legal rows with cell densities from sparse to dense, plus stray indexes.
	function automatic grid_op_t random_op();
		grid_op_t op;
		int pick;
		logic [63:0] a, b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(4))
		0: op.cells = a;
		1: op.cells = a & b;
		2: op.cells = a & b & {$urandom, $urandom};
		3: op.cells = a | b;
		default: op.cells = ($urandom_range(1)) ? '1 : '0;
		endcase
		if ($urandom_range(99) < 85)
			op.idx = 6'($urandom_range(live_rows() - 1));
		else
			op.idx = 6'($urandom_range(63));
		pick = $urandom_range(99);
		if (pick < 40)
			op.func = FUNC_LOAD;
		else if (pick < 72)
			op.func = FUNC_READ;
		else if (pick < 94)
			op.func = FUNC_STEP;
		else
			op.func = FUNC_RSVD;
		return op;
	endfunction

	task automatic write_reg(cfg_reg_t which, logic [6:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= which;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		while (op_queue.size() != 0 || req_bus.valid || pending_answers.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_settings(logic [6:0] r, logic [6:0] c, int count, bit quiet);
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
		calm = quiet;
		repeat (count) op_queue.push_back(random_op());
		drain();
	endtask

	// Request side: hold the beat until taken, then idle or present the next one.
	always @(negedge clk) begin
		grid_op_t op;
		if (!req_bus.valid || req_took) begin
			if (req_gap > 0) begin
				req_bus.valid <= 1'b0;
				req_gap <= req_gap - 1;
			end else if (op_queue.size() != 0) begin
				op = op_queue.pop_front();
				req_bus.valid     <= 1'b1;
				req_bus.func      <= op.func;
				req_bus.row_index <= op.idx;
				req_bus.row_cells <= op.cells;
				req_gap <= pick_gap();
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_bus.ready <= 1'b0;
			rsp_hold <= rsp_hold - 1;
		end else begin
			rsp_bus.ready <= 1'b1;
			rsp_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		grid_op_t op;
		answer_t  want;
		req_took <= req_bus.valid && req_bus.ready;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (pending_answers.size() == 0) begin
				report("unexpected result beat", rsp_bus.cells_out, '0);
			end else begin
				want = pending_answers.pop_front();
				if (rsp_bus.cells_out !== want.cells)
					report("cells_out", rsp_bus.cells_out, want.cells);
				if (rsp_bus.echo_func !== want.func)
					report("echo_func", 64'(rsp_bus.echo_func), 64'(want.func));
				if (rsp_bus.index_error !== want.err)
					report("index_error", 64'(rsp_bus.index_error), 64'(want.err));
			end
		end
		if (req_bus.valid && req_bus.ready) begin
			op.func  = func_t'(req_bus.func);
			op.idx   = req_bus.row_index;
			op.cells = req_bus.row_cells;
			pending_answers.push_back(life_answer(op));
		end
		if (cfg_bus.valid && cfg_bus.ready) begin
			if (cfg_bus.index == REG_ROWS)
				rows_setting = cfg_bus.data;
			else
				cols_setting = cfg_bus.data;
		end
	end

	initial begin
		answer_t lost;
		arst_n            = 1'b0;
		req_bus.valid     = 1'b0;
		req_bus.func      = FUNC_LOAD;
		req_bus.row_index = '0;
		req_bus.row_cells = '0;
		rsp_bus.ready     = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = REG_ROWS;
		cfg_bus.data      = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset grid and register defaults, out-of-range rows, unused code
		push_op(FUNC_READ, 6'd0, '0);
		push_op(FUNC_LOAD, 6'd0, '1);
		push_op(FUNC_READ, 6'd0, '0);
		push_op(FUNC_LOAD, 6'd19, 64'hA5A5_5A5A_0F0F_F0F0);
		push_op(FUNC_READ, 6'd19, '0);
		push_op(FUNC_LOAD, 6'd20, '1);
		push_op(FUNC_READ, 6'd20, '0);
		push_op(FUNC_LOAD, 6'd63, '1);
		push_op(FUNC_READ, 6'd63, '0);
		push_op(FUNC_RSVD, 6'd63, '1);
		push_op(FUNC_LOAD, 6'd0, '0);
		push_op(FUNC_LOAD, 6'd19, '0);
		// blinker: flips between horizontal and vertical
		push_op(FUNC_LOAD, 6'd5, 64'h0E00);
		push_op(FUNC_STEP, 6'd63, '1);
		push_op(FUNC_READ, 6'd4, '0);
		push_op(FUNC_READ, 6'd5, '0);
		push_op(FUNC_READ, 6'd6, '0);
		push_op(FUNC_STEP, 6'd0, '0);
		push_op(FUNC_READ, 6'd5, '0);
		// still block split across both wrap points
		push_op(FUNC_LOAD, 6'd0, (64'd1 << 39) | 64'd1);
		push_op(FUNC_LOAD, 6'd19, (64'd1 << 39) | 64'd1);
		push_op(FUNC_STEP, 6'd0, '0);
		push_op(FUNC_READ, 6'd0, '0);
		push_op(FUNC_READ, 6'd19, '0);
		drain();

		run_settings(7'd64, 7'd64, 170, 1'b0);
		run_settings(7'd1, 7'd1, 60, 1'b0);
		run_settings(7'd0, 7'd0, 60, 1'b1);
		run_settings(7'd127, 7'd127, 170, 1'b0);
		run_settings(7'd2, 7'd3, 80, 1'b0);
		run_settings(7'd3, 7'd2, 80, 1'b1);
		repeat (4)
			run_settings(7'($urandom_range(64, 1)), 7'($urandom_range(64, 1)), 150,
				$urandom_range(3) == 0);

		repeat (20) @(posedge clk);
		while (pending_answers.size() != 0) begin
			lost = pending_answers.pop_front();
			report("missing result", '0, lost.cells);
		end
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### life_generation_engine_core.f
rtl/lgen_pkg.sv
rtl/lgen_req_if.sv
rtl/lgen_rsp_if.sv
rtl/lgen_cfg_if.sv
rtl/lgen_lane.sv
rtl/lgen_row_unit.sv
rtl/lgen_grid_mem.sv
rtl/life_generation_engine_core.sv
bench/tb.sv
